// ===== design/sorted_key_table_top_defines.svh =====
// Assertion macros shared by the sorted key table design files.
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SKT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted key table assertion failed");
// Next-cycle implication.
`define SKT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted key table assertion failed");
`else
`define SKT_ASSERT_IMPL(label, ante, cons)
`define SKT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/skt_pkg.sv =====
// Package with types, constants and codes of the sorted key table.
package skt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND  = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_ENTRY     = 3'd6;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] account_key;
      logic [31:0]        balance_bits;
   } skt_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] entry_key;
      logic [31:0]        entry_balance;
      logic               last;
   } skt_rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        balance;
   } skt_entry_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } skt_cmp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RESULT,
      S_DUMP_RD,
      S_DUMP_OUT
   } skt_state_type;

endpackage

// ===== design/sorted_key_table_top.sv =====
// Sorted key table top level: request port, sequencer and registered response word.
// Holds up to CAPACITY (16) entries sorted by ascending signed key, each with a
// 32-bit balance pattern; insert, remove and dump requests are handled one at a
// time and req_stall stays high until the request's last response word has left
// the sequencer. All work goes through one entry memory with a registered read:
// each scanned entry is read and then compared, each moved entry is read and then
// written, an insert that is placed ends with a place step and then the result
// step, every other outcome with the result step alone, and a dump reads and then
// sends each entry while the response side does not stall. Reset empties the table;
// entry contents are not cleared. Responses pass through an output register, so a
// new request can be taken while the final response word still waits.
`include "sorted_key_table_top_defines.svh"
module sorted_key_table_top
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  skt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output skt_rsp_type rsp_data
);

   logic        seq_ready;
   logic        res_valid;
   logic        res_ready;
   skt_rsp_type res_data;

   logic        out_valid_ff, out_valid_in;
   skt_rsp_type out_data_ff, out_data_in;

   skt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (seq_ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   assign req_stall = !seq_ready;
   assign res_ready = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_ready) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `SKT_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `SKT_ASSERT_IMPL(a_no_overwrite, res_valid && out_valid_ff && rsp_stall, !res_ready)
   `SKT_ASSERT_IMPL(a_entry_fields, rsp_valid && (rsp_data.status != ST_ENTRY),
                    rsp_data.last && (rsp_data.entry_key == 32'sd0)
                    && (rsp_data.entry_balance == 32'd0))

endmodule

// ===== design/skt_cmp.sv =====
// Shared key comparator: equality and signed less-than of two account keys.
module skt_cmp
   import skt_pkg::*;
(
   input  logic signed [31:0] key_a,
   input  logic signed [31:0] key_b,
   output skt_cmp_type        result
);

   assign result.eq = (key_a == key_b);
   assign result.lt = (key_a < key_b);

endmodule

// ===== design/skt_seq.sv =====
// Sequencer with the entry memory: scans, shifts, places and dumps entries.
`include "sorted_key_table_top_defines.svh"
module skt_seq
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  skt_req_type req_data,
   output logic        req_ready,
   output logic        res_valid,
   output skt_rsp_type res_data,
   input  logic        res_ready
);

   skt_state_type state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [31:0]        bal_ff, bal_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [2:0]         status_ff, status_in;

   skt_entry_type mem [CAPACITY];
   skt_entry_type rdata_ff;
   logic [IDX_W-1:0] raddr;
   logic             wen;
   logic [IDX_W-1:0] waddr;
   skt_entry_type    wdata;

   skt_cmp_type cmp;
   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] idx_dec;
   logic             at_end;

   skt_cmp u_cmp (
      .key_a  (key_ff),
      .key_b  (rdata_ff.key),
      .result (cmp)
   );

   assign idx_inc = idx_ff + CNT_W'(1);
   assign idx_dec = idx_ff - CNT_W'(1);
   assign at_end  = (idx_inc == count_ff);

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      bal_ff    <= bal_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      bal_in    = bal_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      raddr     = idx_ff[IDX_W-1:0];
      wen       = 1'b0;
      waddr     = idx_ff[IDX_W-1:0];
      wdata     = rdata_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res_data  = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_data.req_type;
               key_in = req_data.account_key;
               bal_in = req_data.balance_bits;
               idx_in = '0;
               pos_in = '0;
               unique case (req_data.req_type)
                  REQ_INSERT: begin
                     state_in = (count_ff == '0) ? S_PLACE : S_SCAN_RD;
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESULT;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESULT;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     // The unused request code is dropped without a response.
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end

         S_SCAN_CMP: begin
            if (op_ff == REQ_INSERT) begin
               if (cmp.eq) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_RESULT;
               end else if (cmp.lt || at_end) begin
                  // The room check only comes once no duplicate can follow.
                  pos_in = cmp.lt ? idx_ff : count_ff;
                  if (count_ff == CAP_COUNT) begin
                     status_in = ST_FULL;
                     state_in  = S_RESULT;
                  end else if (!cmp.lt) begin
                     state_in = S_PLACE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT_RD;
                  end
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (cmp.eq) begin
                  if (at_end) begin
                     count_in  = idx_ff;
                     status_in = ST_REMOVED;
                     state_in  = S_RESULT;
                  end else begin
                     idx_in   = idx_inc;
                     state_in = S_SHIFT_RD;
                  end
               end else if (cmp.lt || at_end) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_RESULT;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_SHIFT_RD: begin
            // An insert moves entries up from the top, a removal moves them down.
            raddr    = (op_ff == REQ_INSERT) ? idx_dec[IDX_W-1:0] : idx_ff[IDX_W-1:0];
            state_in = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            wen = 1'b1;
            if (op_ff == REQ_INSERT) begin
               waddr  = idx_ff[IDX_W-1:0];
               idx_in = idx_dec;
               state_in = (idx_dec == pos_ff) ? S_PLACE : S_SHIFT_RD;
            end else begin
               waddr = idx_dec[IDX_W-1:0];
               if (at_end) begin
                  count_in  = idx_ff;
                  status_in = ST_REMOVED;
                  state_in  = S_RESULT;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_SHIFT_RD;
               end
            end
         end

         S_PLACE: begin
            wen           = 1'b1;
            waddr         = pos_ff[IDX_W-1:0];
            wdata.key     = key_ff;
            wdata.balance = bal_ff;
            count_in      = count_ff + CNT_W'(1);
            status_in     = ST_INSERTED;
            state_in      = S_RESULT;
         end

         S_RESULT: begin
            res_valid       = 1'b1;
            res_data.status = status_ff;
            res_data.last   = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         S_DUMP_RD: begin
            state_in = S_DUMP_OUT;
         end

         S_DUMP_OUT: begin
            // The read address stays on this entry, so the word holds while stalled.
            res_valid              = 1'b1;
            res_data.status        = ST_ENTRY;
            res_data.entry_key     = rdata_ff.key;
            res_data.entry_balance = rdata_ff.balance;
            res_data.last          = at_end;
            if (res_ready) begin
               if (at_end) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SKT_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CAP_COUNT)
   `SKT_ASSERT_IMPL(a_place_has_room, state_ff == S_PLACE, count_ff < CAP_COUNT)
   `SKT_ASSERT_IMPL(a_shift_above_pos, (state_ff == S_SHIFT_WR) && (op_ff == REQ_INSERT),
                    idx_ff > pos_ff)
   `SKT_ASSERT_NEXT(a_place_then_result, state_ff == S_PLACE, state_ff == S_RESULT)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted key table: directed requests, then random traffic.
`timescale 1ns / 1ps
module testbench;
   import skt_pkg::*;

   // The fourth request code has no name in the package; the block ignores it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4 * CAPACITY + 16;

   typedef struct {
      skt_req_type word;
      bit          typed;
      logic [2:0]  status;
   } plan_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   skt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   skt_rsp_type rsp_data;

   // Shadow copy of the table, updated as each request word is accepted.
   logic signed [31:0] tab_key [CAPACITY];
   logic [31:0]        tab_bal [CAPACITY];
   int                 tab_fill = 0;

   skt_rsp_type  expect_q[$];
   plan_row_type plan_q[$];
   logic [31:0]  key_pool [32];

   bit         drv_typed = 1'b0;
   logic [2:0] drv_status = ST_INSERTED;
   int         burst_left = 0;
   int         failures = 0;
   int         idle_cycles = 0;
   int         requests_seen = 0;
   int         words_seen = 0;
   int         peak_fill = 0;
   int         status_seen [7] = '{default: 0};
   int         stall_mode = 0;
   int         stall_mode_left = 0;
   int         stall_phase = 0;

   sorted_key_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one request to the shadow table and returns the words it should produce.
   function automatic void apply_request(input skt_req_type w, ref skt_rsp_type res[$]);
      skt_rsp_type r;
      int hit;
      int pos;
      r = '0;
      r.last = 1'b1;
      hit = -1;
      for (int i = 0; i < tab_fill; i++)
         if (tab_key[i] == w.account_key) hit = i;
      case (w.req_type)
         REQ_INSERT: begin
            if (hit >= 0) begin
               r.status = ST_DUPLICATE;
            end else if (tab_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               pos = tab_fill;
               for (int i = tab_fill - 1; i >= 0; i--)
                  if ($signed(w.account_key) < $signed(tab_key[i])) pos = i;
               for (int i = tab_fill; i > pos; i--) begin
                  tab_key[i] = tab_key[i - 1];
                  tab_bal[i] = tab_bal[i - 1];
               end
               tab_key[pos] = w.account_key;
               tab_bal[pos] = w.balance_bits;
               tab_fill++;
               r.status = ST_INSERTED;
            end
            res.push_back(r);
         end
         REQ_REMOVE: begin
            if (tab_fill == 0) begin
               r.status = ST_EMPTY;
            end else if (hit < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               for (int i = hit; i + 1 < tab_fill; i++) begin
                  tab_key[i] = tab_key[i + 1];
                  tab_bal[i] = tab_bal[i + 1];
               end
               tab_fill--;
               r.status = ST_REMOVED;
            end
            res.push_back(r);
         end
         REQ_DUMP: begin
            if (tab_fill == 0) begin
               r.status = ST_EMPTY;
               res.push_back(r);
            end else begin
               for (int i = 0; i < tab_fill; i++) begin
                  r.status = ST_ENTRY;
                  r.entry_key = tab_key[i];
                  r.entry_balance = tab_bal[i];
                  r.last = (i + 1 == tab_fill);
                  res.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] rq, input logic [31:0] key,
                                   input logic [31:0] bal, input bit typed,
                                   input logic [2:0] st);
      plan_row_type row;
      row.word.req_type = rq;
      row.word.account_key = key;
      row.word.balance_bits = bal;
      row.typed = typed;
      row.status = st;
      plan_q.push_back(row);
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failures++;
   endtask

   // Sender bursts: a random number of back-to-back words, then a random gap.
   task automatic idle_gap();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
   endtask

   // Called just after a falling edge; returns at the edge that accepts the word.
   task automatic drive_word(input skt_req_type w, input bit typed, input logic [2:0] st);
      drv_typed = typed;
      drv_status = st;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
         req_valid <= 1'b0;
      end while (expect_q.size() != 0);
   endtask

   // The receiver switches between four stall patterns, each chosen at random.
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(50, 300);
      end else begin
         stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= (stall_phase % 4 == 3);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // Response words are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : monitor
      skt_rsp_type want;
      skt_rsp_type fresh_q[$];
      if (!reset) begin
         idle_cycles++;
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            idle_cycles = 0;
            words_seen++;
            if (rsp_data.status <= ST_ENTRY) status_seen[rsp_data.status]++;
            if (expect_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got %h",
                        $time, rsp_data);
               failures++;
            end else begin
               want = expect_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_field("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.entry_key !== want.entry_key)
                  report_field("entry_key", want.entry_key, rsp_data.entry_key);
               if (rsp_data.entry_balance !== want.entry_balance)
                  report_field("entry_balance", want.entry_balance, rsp_data.entry_balance);
               if (rsp_data.last !== want.last)
                  report_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            idle_cycles = 0;
            requests_seen++;
            fresh_q.delete();
            apply_request(req_data, fresh_q);
            if (drv_typed) begin
               want = '0;
               want.status = drv_status;
               want.last = 1'b1;
               expect_q.push_back(want);
            end else begin
               foreach (fresh_q[i]) expect_q.push_back(fresh_q[i]);
            end
            if (tab_fill > peak_fill) peak_fill = tab_fill;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      skt_req_type w;
      int useful;
      int next_pause;
      int roll;
      bit grow;

      // Empty table, ignored code, the key extremes and the duplicate check.
      add_row(REQ_DUMP, 32'h0, 32'h0, 1'b1, ST_EMPTY);
      add_row(REQ_REMOVE, 32'h0, 32'hFFFF_FFFF, 1'b1, ST_EMPTY);
      add_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_INSERTED);
      add_row(REQ_INSERT, 32'h8000_0000, 32'h0, 1'b1, ST_INSERTED);
      add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED);
      add_row(REQ_INSERT, 32'h8000_0000, 32'h5, 1'b1, ST_DUPLICATE);
      add_row(REQ_REMOVE, 32'd12345, 32'h0, 1'b1, ST_NOTFOUND);
      add_row(REQ_DUMP, 32'h0, 32'h0, 1'b0, ST_INSERTED);
      add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, ST_INSERTED);
      add_row(REQ_INSERT, 32'h0, 32'h5A5A_5A5A, 1'b0, ST_INSERTED);
      // Twelve more keys of alternating sign fill the table exactly.
      for (int i = 0; i < 12; i++)
         add_row(REQ_INSERT, (i % 2) ? -(100 * (i + 1)) : 100 * (i + 1), $urandom,
                 1'b0, ST_INSERTED);
      add_row(REQ_INSERT, 32'd77, 32'h1, 1'b1, ST_FULL);
      add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'h2, 1'b1, ST_DUPLICATE);
      add_row(REQ_DUMP, 32'h0, 32'h0, 1'b0, ST_INSERTED);
      add_row(REQ_REMOVE, 32'h8000_0000, 32'h0, 1'b1, ST_REMOVED);
      add_row(REQ_REMOVE, 32'h7FFF_FFFF, 32'h0, 1'b1, ST_REMOVED);

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 32; i++) key_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         idle_gap();
         @(negedge clock);
         drive_word(plan_q[i].word, plan_q[i].typed, plan_q[i].status);
      end
      wait_drained();

      // Keys come mostly from a small pool so that duplicates, hits and a full
      // table are common; the mix swings between growing and draining the table.
      useful = 0;
      next_pause = 150;
      while (useful < RANDOM_ITEMS) begin
         if (useful == next_pause) begin
            wait_drained();
            next_pause += 150;
         end
         grow = ((useful / 40) % 2) == 0;
         idle_gap();
         @(negedge clock);
         roll = $urandom_range(0, 99);
         w.balance_bits = $urandom;
         w.account_key = key_pool[$urandom_range(0, 31)];
         if ($urandom_range(0, 6) == 0) w.account_key = $urandom;
         if (roll < 4) begin
            w.req_type = REQ_UNUSED;
         end else if (roll < 16) begin
            w.req_type = REQ_DUMP;
         end else if (roll < (grow ? 70 : 36)) begin
            w.req_type = REQ_INSERT;
         end else begin
            w.req_type = REQ_REMOVE;
            if (tab_fill > 0 && $urandom_range(0, 3) != 0)
               w.account_key = tab_key[$urandom_range(0, tab_fill - 1)];
         end
         if (w.req_type != REQ_UNUSED) useful++;
         drive_word(w, 1'b0, ST_INSERTED);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d response words; %s %0d of %0d.",
               requests_seen, words_seen, "table fill peaked at", peak_fill, CAPACITY);
      $display("Statuses: inserted %0d, duplicate %0d, removed %0d, not found %0d,",
               status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
               status_seen[ST_REMOVED], status_seen[ST_NOTFOUND]);
      $display("          empty %0d, full %0d, entry %0d.",
               status_seen[ST_EMPTY], status_seen[ST_FULL], status_seen[ST_ENTRY]);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
